@@ rtl/bcgl_pkg.sv @@
// bcgl_pkg: shared constants, types and a function of the color grading block
// depends on nothing
`timescale 1ns / 1ps
package bcgl_pkg;

   localparam int TableDepth = 256;
   localparam int IdxW = $clog2(TableDepth);
   localparam int SizeW = 9;

   typedef enum logic [2:0] {
      CSR_GAIN_RED = 3'd0,
      CSR_GAIN_GREEN = 3'd1,
      CSR_GAIN_BLUE = 3'd2,
      CSR_SATURATION = 3'd3,
      CSR_LUMA_WEIGHTS = 3'd4,
      CSR_SPACING = 3'd5,
      CSR_CURVE_SIZE = 3'd6,
      CSR_UNUSED = 3'd7
   } csr_index_type;

   typedef enum logic [1:0] {
      SPACING_LINEAR = 2'd0,
      SPACING_SQRT = 2'd1,
      SPACING_QUART = 2'd2,
      SPACING_NONE = 2'd3
   } spacing_type;

   typedef enum logic {
      OP_EVAL = 1'b0,
      OP_WRITE = 1'b1
   } op_type;

   // one iteration of a restoring square root on radicand rem/root pair
   typedef struct packed {
      logic [33:0] rem;
      logic [16:0] root;
      logic [33:0] rad;
   } sqrt_step_type;

   function automatic sqrt_step_type sqrt_step(input sqrt_step_type s);
      sqrt_step_type o;
      logic [33:0] trial;
      logic [33:0] r;
      r = {s.rem[31:0], s.rad[33:32]};
      trial = {15'd0, s.root, 2'b01};
      o.rad = {s.rad[31:0], 2'b00};
      if (r >= trial) begin
         o.rem = r - trial;
         o.root = {s.root[15:0], 1'b1};
      end else begin
         o.rem = r;
         o.root = {s.root[15:0], 1'b0};
      end
      return o;
   endfunction

endpackage

@@ rtl/bcgl_sqrt.sv @@
// bcgl_sqrt: pipelined integer square root of a 34-bit radicand, 17 steps
// four steps per stage, one in the last stage, all stages advance together; depends on bcgl_pkg
`timescale 1ns / 1ps
module bcgl_sqrt (
   input  logic        clock,
   input  logic        advance,
   input  logic [33:0] radicand,
   output logic [16:0] root
);

   localparam int Stages = 5;
   localparam int StepsPer = 4;

   bcgl_pkg::sqrt_step_type stage_ff [Stages];
   bcgl_pkg::sqrt_step_type stage_in [Stages];

   always_comb begin
      bcgl_pkg::sqrt_step_type s;
      for (int i = 0; i < Stages; i++) begin
         if (i == 0) begin
            s.rem = '0;
            s.root = '0;
            s.rad = radicand;
         end else begin
            s = stage_ff[i-1];
         end
         for (int k = 0; k < StepsPer; k++) begin
            if (i * StepsPer + k < 17) begin
               s = bcgl_pkg::sqrt_step(s);
            end
         end
         stage_in[i] = s;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < Stages; i++) begin
            stage_ff[i] <= stage_in[i];
         end
      end
   end

   assign root = stage_ff[Stages-1].root;

endmodule

@@ rtl/bcgl_curve.sv @@
// bcgl_curve: one curve channel, table memory and interpolation stages
// depends on bcgl_pkg
`timescale 1ns / 1ps
module bcgl_curve (
   input  logic                      clock,
   input  logic                      advance,
   input  logic                      wr_en,
   input  logic [bcgl_pkg::IdxW-1:0] wr_index,
   input  logic signed [15:0]        wr_data,
   input  logic [16:0]               position,
   input  logic [bcgl_pkg::SizeW-1:0] size,
   output logic signed [15:0]        value
);

   logic signed [15:0] mem0 [bcgl_pkg::TableDepth];
   logic signed [15:0] mem1 [bcgl_pkg::TableDepth];

   logic [25:0] p_ff;
   logic [bcgl_pkg::SizeW-1:0] last_ff;
   logic [bcgl_pkg::IdxW-1:0] a0_in, a1_in;
   logic clamp_in, clamp_ff;
   logic [15:0] frac_ff;
   logic signed [15:0] v0_ff, v1_ff;
   logic signed [33:0] prod_ff;
   logic signed [15:0] v0b_ff;
   logic [bcgl_pkg::SizeW-1:0] base_w;

   // position times (n - 1)
   always_ff @(posedge clock) begin
      if (advance) begin
         p_ff <= 26'(position * (size - 9'd1));
         last_ff <= size - 9'd1;
      end
   end

   assign base_w = p_ff[24:16];
   assign clamp_in = p_ff[25] || (base_w >= last_ff);
   assign a0_in = clamp_in ? last_ff[bcgl_pkg::IdxW-1:0] : base_w[bcgl_pkg::IdxW-1:0];
   assign a1_in = a0_in + 1'b1;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem0[wr_index] <= wr_data;
         mem1[wr_index] <= wr_data;
      end
      if (advance) begin
         v0_ff <= mem0[a0_in];
         v1_ff <= mem1[a1_in];
         clamp_ff <= clamp_in;
         frac_ff <= p_ff[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         prod_ff <= clamp_ff ? 34'sd0
            : (34'(v1_ff) - 34'(v0_ff)) * $signed({18'd0, frac_ff});
         v0b_ff <= v0_ff;
      end
   end

   logic signed [33:0] rnd;
   assign rnd = (prod_ff + 34'sd32768) >>> 16;
   always_ff @(posedge clock) begin
      if (advance) begin
         value <= 16'(34'(v0b_ff) + rnd);
      end
   end

endmodule

@@ rtl/bcgl_color.sv @@
// bcgl_color: exposure gain, luma, saturation and spacing root stages
// depends on bcgl_pkg and bcgl_sqrt
`timescale 1ns / 1ps
module bcgl_color (
   input  logic        clock,
   input  logic        advance,
   input  logic [15:0] red_in,
   input  logic [15:0] green_in,
   input  logic [15:0] blue_in,
   input  logic [15:0] gain_red,
   input  logic [15:0] gain_green,
   input  logic [15:0] gain_blue,
   input  logic [15:0] saturation,
   input  logic [47:0] weights,
   input  logic [1:0]  spacing,
   output logic [16:0] pos_red,
   output logic [16:0] pos_green,
   output logic [16:0] pos_blue
);

   logic [32:0] e_ff [3];
   logic [15:0] w [3];
   logic [48:0] wp_ff [3];
   logic [32:0] e2_ff [3];
   logic [49:0] grey_w;
   logic [33:0] grey_ff;
   logic [32:0] e3_ff [3];
   logic signed [51:0] sprod_ff [3];
   logic [33:0] grey2_ff;
   logic [12:0] s_ff [3];
   logic [1:0] sp_ff [13];
   logic [16:0] r1 [3];
   logic [16:0] r2 [3];

   assign w[0] = weights[47:32];
   assign w[1] = weights[31:16];
   assign w[2] = weights[15:0];

   always_ff @(posedge clock) begin
      if (advance) begin
         e_ff[0] <= 33'((33'(red_in) * gain_red + 33'd2048) >> 12);
         e_ff[1] <= 33'((33'(green_in) * gain_green + 33'd2048) >> 12);
         e_ff[2] <= 33'((33'(blue_in) * gain_blue + 33'd2048) >> 12);
         for (int c = 0; c < 3; c++) begin
            wp_ff[c] <= 49'(w[c]) * 49'(e_ff[c][20:0]);
            e2_ff[c] <= e_ff[c];
         end
         grey_ff <= 34'(grey_w >> 16);
         for (int c = 0; c < 3; c++) begin
            e3_ff[c] <= e2_ff[c];
         end
         for (int c = 0; c < 3; c++) begin
            sprod_ff[c] <= $signed({36'd0, saturation})
               * (52'(e3_ff[c]) - 52'(grey_ff));
         end
         grey2_ff <= grey_ff;
      end
   end

   assign grey_w = 50'(wp_ff[0]) + 50'(wp_ff[1]) + 50'(wp_ff[2]) + 50'd32768;

   always_ff @(posedge clock) begin
      logic signed [52:0] s;
      if (advance) begin
         for (int c = 0; c < 3; c++) begin
            s = $signed(53'(grey2_ff)) + ((53'(sprod_ff[c]) + 53'sd2048) >>> 12);
            if (s < 0) s_ff[c] <= '0;
            else if (s > 53'sd4096) s_ff[c] <= 13'd4096;
            else s_ff[c] <= s[12:0];
         end
         sp_ff[0] <= spacing;
         for (int i = 1; i < 13; i++) sp_ff[i] <= sp_ff[i-1];
      end
   end

   for (genvar c = 0; c < 3; c++) begin : g_root
      bcgl_sqrt u_sq1 (
         .clock(clock), .advance(advance),
         .radicand({1'b0, s_ff[c], 20'd0}), .root(r1[c])
      );
      bcgl_sqrt u_sq2 (
         .clock(clock), .advance(advance),
         .radicand({1'b0, r1[c], 16'd0}), .root(r2[c])
      );
   end

   // linear path and first root delayed to match the second root
   logic [16:0] lin_r [3][10];
   logic [16:0] sq_r [3][5];
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int c = 0; c < 3; c++) begin
            lin_r[c][0] <= {s_ff[c], 4'd0};
            for (int i = 1; i < 10; i++) lin_r[c][i] <= lin_r[c][i-1];
            sq_r[c][0] <= r1[c];
            for (int i = 1; i < 5; i++) sq_r[c][i] <= sq_r[c][i-1];
         end
      end
   end

   logic [16:0] pos [3];
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         case (bcgl_pkg::spacing_type'(sp_ff[12]))
            bcgl_pkg::SPACING_LINEAR: pos[c] = lin_r[c][9];
            bcgl_pkg::SPACING_SQRT: pos[c] = sq_r[c][4];
            bcgl_pkg::SPACING_QUART: pos[c] = r2[c];
            default: pos[c] = '0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         pos_red <= pos[0];
         pos_green <= pos[1];
         pos_blue <= pos[2];
      end
   end

endmodule

@@ rtl/baked_color_grading_lut.sv @@
// baked_color_grading_lut: top level, registers, valid pipeline and table write delay
// depends on bcgl_pkg, bcgl_color and bcgl_curve
//
// use: pixels and table writes arrive on req_ (valid/stall); op selects evaluate or
// table write. a write transfer stores red/green/blue entries at entry_index and
// gives no result. an evaluate transfer gives one rsp_ transfer with the graded
// channels. registers are written on csr_ (valid/ready, ready always high); the
// user must write them only while the block is idle; the block does not enforce it.
// one item enters per cycle while no stall holds the pipeline; items pass through
// the gain, luma, saturation, two pipelined root units and interpolation stages.
// a table write is held in a delay line before it reaches the memories, so pixels
// see exactly the writes that came before them. the whole pipeline moves as one;
// a stall on rsp_ with a full output register freezes it and req_stall rises, so
// nothing is lost or repeated. reset clears valid bits and loads register
// defaults; tables are not cleared and must be written before pixels read them.
`timescale 1ns / 1ps
module baked_color_grading_lut (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_op,
   input  logic [15:0] req_red_in,
   input  logic [15:0] req_green_in,
   input  logic [15:0] req_blue_in,
   input  logic [7:0]  req_entry_index,
   input  logic signed [15:0] req_entry_red,
   input  logic signed [15:0] req_entry_green,
   input  logic signed [15:0] req_entry_blue,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic signed [15:0] rsp_red_out,
   output logic signed [15:0] rsp_green_out,
   output logic signed [15:0] rsp_blue_out,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [47:0] csr_data
);

   localparam int Depth = 20;
   localparam int WrDelay = 16;

   logic [15:0] gain_r_ff, gain_g_ff, gain_b_ff, sat_ff;
   logic [47:0] wts_ff;
   logic [1:0] spacing_ff;
   logic [8:0] size_ff, size_eff;
   logic [Depth-1:0] vld_ff;
   logic advance, wr_en;
   logic [16:0] pr, pg, pb;
   logic signed [15:0] vr, vg, vb;
   logic [WrDelay-1:0] wr_vld_ff;
   logic [7:0] wr_idx_ff [WrDelay];
   logic signed [15:0] wr_red_ff [WrDelay];
   logic signed [15:0] wr_green_ff [WrDelay];
   logic signed [15:0] wr_blue_ff [WrDelay];

   assign csr_ready = 1'b1;
   assign advance = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;
   assign wr_en = advance && wr_vld_ff[WrDelay-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_r_ff <= 16'd4096;
         gain_g_ff <= 16'd4096;
         gain_b_ff <= 16'd4096;
         sat_ff <= 16'd4096;
         wts_ff <= 48'h400080004000;
         spacing_ff <= '0;
         size_ff <= 9'd256;
      end else if (csr_valid) begin
         unique case (bcgl_pkg::csr_index_type'(csr_index))
            bcgl_pkg::CSR_GAIN_RED: gain_r_ff <= csr_data[15:0];
            bcgl_pkg::CSR_GAIN_GREEN: gain_g_ff <= csr_data[15:0];
            bcgl_pkg::CSR_GAIN_BLUE: gain_b_ff <= csr_data[15:0];
            bcgl_pkg::CSR_SATURATION: sat_ff <= csr_data[15:0];
            bcgl_pkg::CSR_LUMA_WEIGHTS: wts_ff <= csr_data;
            bcgl_pkg::CSR_SPACING: spacing_ff <= csr_data[1:0];
            bcgl_pkg::CSR_CURVE_SIZE: size_ff <= csr_data[8:0];
            default: ;
         endcase
      end
   end

   assign size_eff = (size_ff < 9'd2) ? 9'd2
      : (size_ff > 9'(bcgl_pkg::TableDepth)) ? 9'(bcgl_pkg::TableDepth) : size_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[Depth-2:0],
                    req_valid && (req_op == bcgl_pkg::OP_EVAL)};
      end
   end
   assign rsp_valid = vld_ff[Depth-1];

   // table writes wait until earlier pixels have read the tables
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_vld_ff <= '0;
      end else if (advance) begin
         wr_vld_ff <= {wr_vld_ff[WrDelay-2:0],
                       req_valid && (req_op == bcgl_pkg::OP_WRITE)};
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         wr_idx_ff[0] <= req_entry_index;
         wr_red_ff[0] <= req_entry_red;
         wr_green_ff[0] <= req_entry_green;
         wr_blue_ff[0] <= req_entry_blue;
         for (int i = 1; i < WrDelay; i++) begin
            wr_idx_ff[i] <= wr_idx_ff[i-1];
            wr_red_ff[i] <= wr_red_ff[i-1];
            wr_green_ff[i] <= wr_green_ff[i-1];
            wr_blue_ff[i] <= wr_blue_ff[i-1];
         end
      end
   end

   bcgl_color u_color (
      .clock(clock), .advance(advance),
      .red_in(req_red_in), .green_in(req_green_in), .blue_in(req_blue_in),
      .gain_red(gain_r_ff), .gain_green(gain_g_ff), .gain_blue(gain_b_ff),
      .saturation(sat_ff), .weights(wts_ff), .spacing(spacing_ff),
      .pos_red(pr), .pos_green(pg), .pos_blue(pb)
   );

   bcgl_curve u_red (
      .clock(clock), .advance(advance), .wr_en(wr_en),
      .wr_index(wr_idx_ff[WrDelay-1]), .wr_data(wr_red_ff[WrDelay-1]),
      .position(pr), .size(size_eff), .value(vr)
   );
   bcgl_curve u_green (
      .clock(clock), .advance(advance), .wr_en(wr_en),
      .wr_index(wr_idx_ff[WrDelay-1]), .wr_data(wr_green_ff[WrDelay-1]),
      .position(pg), .size(size_eff), .value(vg)
   );
   bcgl_curve u_blue (
      .clock(clock), .advance(advance), .wr_en(wr_en),
      .wr_index(wr_idx_ff[WrDelay-1]), .wr_data(wr_blue_ff[WrDelay-1]),
      .position(pb), .size(size_eff), .value(vb)
   );

   assign rsp_red_out = vr;
   assign rsp_green_out = vg;
   assign rsp_blue_out = vb;

endmodule
